>>> sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/fatl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fatl_pkg;

   localparam int ELAPSED_W   = 32;
   localparam int AVG_W       = 32;
   localparam int SLEEP_W     = 20;
   localparam int FPS_W       = 20;
   localparam int PERIOD_W    = 20;
   localparam int WINLEN_W    = 7;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 20;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 72;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PERIOD = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEN   = 4'd1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd16666;
   localparam logic [WINLEN_W-1:0] WINLEN_RESET = 7'd60;
   localparam logic [FPS_W-1:0]    USEC_PER_SEC = 20'd1000000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_WALK,
      ST_DIVIDE,
      ST_WAIT,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

>>> sv/frame_time_average_limiter.sv
// channel  | direction | handshake              | payload
// req      | in        | req_tvalid/req_tready  | req_tdata: elapsed_us
// rsp      | out       | rsp_tvalid/rsp_tready  | rsp_tdata: avg, sleep, fps
// csr      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// one item at a time: the ring slots are read back one per cycle, then a restoring
// divider takes one quotient bit per cycle over the 32 + log2(MAX_WINDOW) bit sum.
// after reset a clearing pass writes zero to all MAX_WINDOW ring slots; req_tready
// is low during it, csr writes are taken at all times.
// a result waits in the rsp register; the next item is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module frame_time_average_limiter #(
   parameter int MAX_WINDOW = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [fatl_pkg::REQ_DATA_W-1:0]      req_tdata,  // elapsed_us
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [fatl_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // avg_period_us, sleep_us, last_fps
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [fatl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fatl_pkg::CSR_DATA_W-1:0]      csr_data
);

   import fatl_pkg::*;

   localparam int CW     = $clog2(MAX_WINDOW);
   localparam int LW     = $clog2(MAX_WINDOW + 1);
   localparam int SW     = ELAPSED_W + CW;
   localparam int FPS_NW = ELAPSED_W + 1;

   state_type state_ff, state_in;

   logic [PERIOD_W-1:0]  period_ff;
   logic [WINLEN_W-1:0]  winlen_ff;
   logic [LW-1:0]        eff_len;

   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [ELAPSED_W-1:0] stored_ff, stored_in;
   logic [SLEEP_W-1:0]   sleep_ff, sleep_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [CW-1:0]        slot_ff, slot_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        clr_ff, clr_in;
   logic [LW-1:0]        issued_ff, issued_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [LW-1:0]        lenm1;
   logic [CW-1:0]        wslot;
   logic                 walk_stop;
   logic                 issue;

   logic                 ram_wr_en;
   logic [CW-1:0]        ram_wr_addr;
   logic [ELAPSED_W-1:0] ram_wr_data;
   logic [ELAPSED_W-1:0] ram_rd_data;

   logic                 div_start;
   logic                 avg_busy;
   logic                 fps_busy;
   logic [SW-1:0]        avg_quo;
   logic [FPS_NW-1:0]    fps_quo;
   logic [AVG_W-1:0]     avg_val;
   logic [FPS_W-1:0]     fps_val;
   logic                 load_rsp;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         winlen_ff <= WINLEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_PERIOD: period_ff <= csr_data[PERIOD_W-1:0];
            CSR_WINDOW_LEN:   winlen_ff <= csr_data[WINLEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      if (winlen_ff == '0) begin
         eff_len = LW'(1);
      end else if (32'(winlen_ff) > MAX_WINDOW) begin
         eff_len = LW'(MAX_WINDOW);
      end else begin
         eff_len = LW'(winlen_ff);
      end
   end

   assign lenm1 = len_ff - LW'(1);
   assign wslot = (LW'(slot_ff) >= len_ff) ? '0 : slot_ff;
   assign issue = (issued_ff < lenm1);
   assign walk_stop = rd_valid_ff &&
                      ((ram_rd_data == '0) || (LW'(cnt_ff) + LW'(1) == lenm1));

   assign req_tready = (state_ff == ST_IDLE);
   assign load_rsp   = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CW'(MAX_WINDOW - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = (len_ff == LW'(1)) ? ST_DIVIDE : ST_WALK;
         end
         ST_WALK: begin
            if (walk_stop) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (!avg_busy && !fps_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      elapsed_in   = elapsed_ff;
      stored_in    = stored_ff;
      sleep_in     = sleep_ff;
      len_in       = len_ff;
      slot_in      = slot_ff;
      pos_in       = pos_ff;
      clr_in       = clr_ff;
      issued_in    = issued_ff;
      rd_valid_in  = rd_valid_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wslot;
      ram_wr_data  = stored_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + CW'(1);
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               elapsed_in = req_tdata[ELAPSED_W-1:0];
               len_in     = eff_len;
               if (req_tdata[ELAPSED_W-1:0] < ELAPSED_W'(period_ff)) begin
                  stored_in = ELAPSED_W'(period_ff);
                  sleep_in  = period_ff - req_tdata[SLEEP_W-1:0];
               end else begin
                  stored_in = req_tdata[ELAPSED_W-1:0];
                  sleep_in  = '0;
               end
            end
         end
         ST_WRITE: begin
            ram_wr_en   = 1'b1;
            slot_in     = (LW'(wslot) + LW'(1) == len_ff) ? '0 : wslot + CW'(1);
            pos_in      = wslot;
            issued_in   = '0;
            rd_valid_in = 1'b0;
            sum_in      = '0;
            cnt_in      = '0;
         end
         ST_WALK: begin
            rd_valid_in = issue;
            if (issue) begin
               issued_in = issued_ff + LW'(1);
               pos_in    = (pos_ff == '0) ? CW'(lenm1) : pos_ff - CW'(1);
            end
            if (rd_valid_ff && (ram_rd_data != '0)) begin
               sum_in = sum_ff + SW'(ram_rd_data);
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_DIVIDE: begin
            div_start = 1'b1;
         end
         ST_WAIT: ;
         ST_RESULT: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {fps_val, sleep_ff, avg_val};
            end
         end
         default: ;
      endcase
   end

   assign avg_val = (cnt_ff == '0) ? '0 : avg_quo[AVG_W-1:0];
   assign fps_val = (elapsed_ff == '0) ? USEC_PER_SEC : fps_quo[FPS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         slot_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         issued_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         slot_ff      <= slot_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         issued_ff    <= issued_in;
         cnt_ff       <= cnt_in;
      end
      elapsed_ff  <= elapsed_in;
      stored_ff   <= stored_in;
      sleep_ff    <= sleep_in;
      len_ff      <= len_in;
      pos_ff      <= pos_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   fatl_ram #(
      .WIDTH (ELAPSED_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   fatl_div #(
      .NUM_W (SW),
      .DEN_W (CW)
   ) u_avg_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum_ff),
      .den   (cnt_ff),
      .busy  (avg_busy),
      .quo   (avg_quo)
   );

   fatl_div #(
      .NUM_W (FPS_NW),
      .DEN_W (FPS_NW)
   ) u_fps_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (FPS_NW'(2 * 1000000) + FPS_NW'(elapsed_ff)),
      .den   ({elapsed_ff, 1'b0}),
      .busy  (fps_busy),
      .quo   (fps_quo)
   );

   `ASSERT_NEXT(a_accept_to_write, clock, reset, req_tvalid && req_tready, state_ff == ST_WRITE)
   `ASSERT_IMPL(a_walk_count, clock, reset, state_ff == ST_WALK, LW'(cnt_ff) < len_ff)
   `ASSERT_IMPL(a_rsp_from_result, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_RESULT)
   `ASSERT_IMPL(a_no_write_while_walk, clock, reset, state_ff == ST_WALK, !ram_wr_en)

endmodule

`default_nettype wire

>>> sv/fatl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fatl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> sv/fatl_div.sv
`timescale 1ns / 1ps
`default_nettype none

module fatl_div #(
   parameter int NUM_W = 38,
   parameter int DEN_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic      [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quo  = num_ff;

endmodule

`default_nettype wire
